@@ hw/rtl/aef_pkg.sv @@
// shared types and constants for the aging event fifo
package aef_pkg;

	localparam int CODE_W  = 8;
	localparam int DELTA_W = 16;
	localparam int WIN_W   = 31;
	localparam int CAP_W   = 5;
	localparam int OCC_W   = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(200);
	localparam logic [CAP_W-1:0] CAP_RESET    = CAP_W'(16);

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b1;

	typedef enum logic [1:0] {
		FUNC_PUSH    = 2'd0,
		FUNC_CONSUME = 2'd1,
		FUNC_TICK    = 2'd2,
		FUNC_CLEAR   = 2'd3
	} func_t;

	typedef struct packed {
		logic  latch;
		logic  push;
		logic  adv;
		logic  scan_start;
		logic  compact;
		logic  scan;
		logic  fin;
		func_t op;
	} aef_cmd_t;

	typedef struct packed {
		logic scan_done;
	} aef_sts_t;

endpackage

@@ hw/rtl/aging_event_fifo.sv @@
// top level of the aging event fifo
// Bounded ring fifo of timestamped action codes with age expiry and drop-oldest on push.
// One item is handled at a time and every item gives exactly one result. The cost of a
// consume, push or tick is the walk over the stored entries through the entry memory's
// single read port, one entry per cycle, which finds the oldest live code and, for
// consume and tick, squeezes expired entries out of the ring. A new item is taken while
// the previous result still waits in the output register. window_ticks and
// capacity_limit are written through cfg_we/cfg_idx/cfg_wdata; the user must do so only
// while the block is idle, as the block itself does not enforce it.
module aging_event_fifo #(
	parameter int DEPTH     = 16,
	parameter int TIME_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [aef_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [aef_pkg::WIN_W-1:0]        cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       func,
	input  logic [aef_pkg::CODE_W-1:0]       action_code,
	input  logic [aef_pkg::DELTA_W-1:0]      delta_ticks,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [aef_pkg::CODE_W-1:0]       taken_code,
	output logic [aef_pkg::CODE_W-1:0]       next_code,
	output logic                             pending,
	output logic [aef_pkg::OCC_W-1:0]        occupancy,
	output logic                             accepted,
	output logic                             dropped_oldest
);

	aef_pkg::aef_cmd_t cmd;
	aef_pkg::aef_sts_t sts;

	aef_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	aef_dp #(
		.DEPTH     (DEPTH),
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_wdata      (cfg_wdata),
		.action_code    (action_code),
		.delta_ticks    (delta_ticks),
		.taken_code     (taken_code),
		.next_code      (next_code),
		.pending        (pending),
		.occupancy      (occupancy),
		.accepted       (accepted),
		.dropped_oldest (dropped_oldest)
	);

	// an eviction only happens as part of a stored push
	a_drop_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (accepted || !dropped_oldest))
		else $error("eviction reported without a stored item");

	// stored codes are never zero, so a live entry always shows a nonzero code
	a_pending_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pending == (next_code != '0)))
		else $error("pending flag disagrees with next code");

	// one item at a time: an accepted item closes the input side next cycle
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while an item is in flight");

	// a consume result never reports a stored push
	a_consume_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && taken_code != '0) |-> !accepted)
		else $error("consume result marked as accepted push");

endmodule

@@ hw/rtl/aef_dp.sv @@
// datapath: entry memory, pointers, time counter, expiry scan and result registers
module aef_dp #(
	parameter int DEPTH     = 16,
	parameter int TIME_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  aef_pkg::aef_cmd_t                cmd,
	output aef_pkg::aef_sts_t                sts,
	input  logic                             cfg_we,
	input  logic [aef_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [aef_pkg::WIN_W-1:0]        cfg_wdata,
	input  logic [aef_pkg::CODE_W-1:0]       action_code,
	input  logic [aef_pkg::DELTA_W-1:0]      delta_ticks,
	output logic [aef_pkg::CODE_W-1:0]       taken_code,
	output logic [aef_pkg::CODE_W-1:0]       next_code,
	output logic                             pending,
	output logic [aef_pkg::OCC_W-1:0]        occupancy,
	output logic                             accepted,
	output logic                             dropped_oldest
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int CW_C  = (CNT_W > aef_pkg::CAP_W) ? CNT_W : aef_pkg::CAP_W;
	localparam int CMP_W = (TIME_BITS > aef_pkg::WIN_W) ? TIME_BITS : aef_pkg::WIN_W;
	localparam int EW    = aef_pkg::CODE_W + TIME_BITS;

	// ring index: head plus offset, wrapped once
	function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] h,
			input logic [CNT_W-1:0] i);
		logic [SUM_W-1:0] s;
		s = SUM_W'(h) + SUM_W'(i);
		if (s >= SUM_W'(DEPTH)) begin
			s = s - SUM_W'(DEPTH);
		end
		return s[PTR_W-1:0];
	endfunction

	logic [EW-1:0] mem [DEPTH];

	logic [PTR_W-1:0]             head_q;
	logic [CNT_W-1:0]             count_q;
	logic [TIME_BITS-1:0]         now_q;
	logic [aef_pkg::WIN_W-1:0]    window_q;
	logic [aef_pkg::CAP_W-1:0]    cap_q;
	logic [aef_pkg::CODE_W-1:0]   code_q;
	logic [aef_pkg::DELTA_W-1:0]  delta_q;
	logic                         drop_q;
	logic                         compact_q;
	logic [CNT_W-1:0]             rd_idx_q;
	logic [CNT_W-1:0]             kept_q;
	logic                         valid_s1;
	logic [aef_pkg::CODE_W-1:0]   rd_code_s1;
	logic [TIME_BITS-1:0]         rd_stamp_s1;
	logic [aef_pkg::CODE_W-1:0]   first_q;
	logic [aef_pkg::CODE_W-1:0]   second_q;

	logic [aef_pkg::CODE_W-1:0]   taken_q;
	logic [aef_pkg::CODE_W-1:0]   next_q;
	logic                         pend_q;
	logic [aef_pkg::OCC_W-1:0]    occ_q;
	logic                         acc_q;
	logic                         dropo_q;

	// push path
	logic [CW_C-1:0]  cap_eff;
	logic [CW_C-1:0]  cnt_ext;
	logic             push_live;
	logic             drop_now;

	// scan path
	logic             issue;
	logic [PTR_W-1:0] rd_slot;
	logic [TIME_BITS-1:0] age;
	logic             expired;
	logic             keep;

	// memory write port
	logic             wr_en;
	logic [PTR_W-1:0] wr_slot;
	logic [EW-1:0]    wr_data;

	// finish
	logic [CNT_W-1:0]           fin_count;
	logic [PTR_W-1:0]           fin_head;
	logic [aef_pkg::CODE_W-1:0] fin_taken;
	logic [aef_pkg::CODE_W-1:0] fin_next;
	logic                       fin_pend;
	logic                       fin_acc;
	logic                       fin_drop;
	logic [CW_C-1:0]            fin_cnt_ext;

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CW_C'(1);
		end else if (CW_C'(cap_q) > CW_C'(DEPTH)) begin
			cap_eff = CW_C'(DEPTH);
		end else begin
			cap_eff = CW_C'(cap_q);
		end
	end

	assign cnt_ext   = CW_C'(count_q);
	assign push_live = (code_q != '0);
	assign drop_now  = push_live && (cnt_ext >= cap_eff) && (count_q != '0);

	assign issue   = cmd.scan && (rd_idx_q < count_q);
	assign rd_slot = slot_of(head_q, rd_idx_q);
	assign age     = now_q - rd_stamp_s1;
	assign expired = CMP_W'(age) > CMP_W'(window_q);
	assign keep    = valid_s1 && !expired;

	assign sts.scan_done = cmd.scan && !issue && !valid_s1;

	// the new entry lands at head+count whether or not the oldest is dropped
	always_comb begin
		wr_en   = 1'b0;
		wr_slot = slot_of(head_q, count_q);
		wr_data = {code_q, now_q};
		if (cmd.push && push_live) begin
			wr_en = 1'b1;
		end else if (keep && compact_q) begin
			wr_en   = 1'b1;
			wr_slot = slot_of(head_q, kept_q);
			wr_data = {rd_code_s1, rd_stamp_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_slot] <= wr_data;
		end
		if (issue) begin
			{rd_code_s1, rd_stamp_s1} <= mem[rd_slot];
		end
	end

	always_comb begin
		fin_count = count_q;
		fin_head  = head_q;
		fin_taken = '0;
		fin_next  = '0;
		fin_pend  = 1'b0;
		fin_acc   = 1'b0;
		fin_drop  = 1'b0;
		case (cmd.op)
			aef_pkg::FUNC_PUSH: begin
				fin_pend = (kept_q != '0);
				fin_next = fin_pend ? first_q : '0;
				fin_acc  = push_live;
				fin_drop = drop_q;
			end
			aef_pkg::FUNC_CONSUME: begin
				if (kept_q != '0) begin
					fin_taken = first_q;
					fin_pend  = (kept_q > CNT_W'(1));
					fin_next  = fin_pend ? second_q : '0;
					fin_count = kept_q - CNT_W'(1);
					fin_head  = slot_of(head_q, CNT_W'(1));
				end else begin
					fin_count = '0;
				end
			end
			aef_pkg::FUNC_TICK: begin
				fin_count = kept_q;
				fin_pend  = (kept_q != '0);
				fin_next  = fin_pend ? first_q : '0;
			end
			aef_pkg::FUNC_CLEAR: begin
				fin_count = '0;
				fin_head  = '0;
			end
			default: begin
				fin_count = count_q;
			end
		endcase
	end

	assign fin_cnt_ext = CW_C'(fin_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			count_q   <= '0;
			now_q     <= '0;
			window_q  <= aef_pkg::WINDOW_RESET;
			cap_q     <= aef_pkg::CAP_RESET;
			drop_q    <= 1'b0;
			compact_q <= 1'b0;
			rd_idx_q  <= '0;
			kept_q    <= '0;
			valid_s1  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					aef_pkg::CFG_WINDOW:   window_q <= cfg_wdata;
					aef_pkg::CFG_CAPACITY: cap_q    <= cfg_wdata[aef_pkg::CAP_W-1:0];
					default:               window_q <= window_q;
				endcase
			end
			if (cmd.push) begin
				drop_q <= drop_now;
				if (push_live && !drop_now) begin
					count_q <= count_q + CNT_W'(1);
				end
				if (drop_now) begin
					head_q <= slot_of(head_q, CNT_W'(1));
				end
			end
			if (cmd.adv) begin
				now_q <= now_q + TIME_BITS'(delta_q);
			end
			if (cmd.scan_start) begin
				compact_q <= cmd.compact;
				rd_idx_q  <= '0;
				kept_q    <= '0;
				valid_s1  <= 1'b0;
			end else begin
				valid_s1 <= issue;
				if (issue) begin
					rd_idx_q <= rd_idx_q + CNT_W'(1);
				end
				if (keep) begin
					kept_q <= kept_q + CNT_W'(1);
				end
			end
			if (cmd.fin) begin
				count_q <= fin_count;
				head_q  <= fin_head;
			end
		end
	end

	// item latch and result registers; the first and second survivors of the walk feed the result
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			code_q  <= action_code;
			delta_q <= delta_ticks;
		end
		if (keep && kept_q == CNT_W'(0)) begin
			first_q <= rd_code_s1;
		end
		if (keep && kept_q == CNT_W'(1)) begin
			second_q <= rd_code_s1;
		end
		if (cmd.fin) begin
			taken_q <= fin_taken;
			next_q  <= fin_next;
			pend_q  <= fin_pend;
			occ_q   <= fin_cnt_ext[aef_pkg::OCC_W-1:0];
			acc_q   <= fin_acc;
			dropo_q <= fin_drop;
		end
	end

	assign taken_code     = taken_q;
	assign next_code      = next_q;
	assign pending        = pend_q;
	assign occupancy      = occ_q;
	assign accepted       = acc_q;
	assign dropped_oldest = dropo_q;

endmodule

@@ hw/rtl/aef_ctrl.sv @@
// controller: operation sequencing and channel handshakes
module aef_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        func,
	output logic              out_valid,
	input  logic              out_stall,
	output aef_pkg::aef_cmd_t cmd,
	input  aef_pkg::aef_sts_t sts
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_PUSH = 5'b00010,
		S_ADV  = 5'b00100,
		S_SCAN = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t            state_q;
	state_t            state_d;
	aef_pkg::func_t    op_q;
	aef_pkg::func_t    func_in;
	logic              out_valid_q;
	logic              take;
	logic              fin_go;

	assign func_in  = aef_pkg::func_t'(func);
	assign in_stall = (state_q != S_IDLE);
	assign take     = in_valid && (state_q == S_IDLE);
	// result register frees up in the same cycle it is taken
	assign fin_go   = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.op         = op_q;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					cmd.latch = 1'b1;
					case (func_in)
						aef_pkg::FUNC_PUSH:    state_d = S_PUSH;
						aef_pkg::FUNC_CONSUME: begin
							cmd.scan_start = 1'b1;
							cmd.compact    = 1'b1;
							state_d        = S_SCAN;
						end
						aef_pkg::FUNC_TICK:    state_d = S_ADV;
						aef_pkg::FUNC_CLEAR:   state_d = S_FIN;
						default:               state_d = S_FIN;
					endcase
				end
			end
			S_PUSH: begin
				cmd.push       = 1'b1;
				cmd.scan_start = 1'b1;
				state_d        = S_SCAN;
			end
			S_ADV: begin
				cmd.adv        = 1'b1;
				cmd.scan_start = 1'b1;
				cmd.compact    = 1'b1;
				state_d        = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (fin_go) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= aef_pkg::FUNC_PUSH;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				op_q <= func_in;
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ sim/aging_event_fifo_tb.sv @@
// self-checking testbench for the aging event fifo
`timescale 1ns / 1ps

module aging_event_fifo_tb;

	localparam int FIFO_DEPTH = 16;

	typedef struct packed {
		aef_pkg::func_t                  op;
		logic [aef_pkg::CODE_W-1:0]      code;
		logic [aef_pkg::DELTA_W-1:0]     delta;
	} fifo_req_t;

	typedef struct packed {
		logic [aef_pkg::CODE_W-1:0] taken;
		logic [aef_pkg::CODE_W-1:0] next;
		logic                       pend;
		logic [aef_pkg::OCC_W-1:0]  occ;
		logic                       acc;
		logic                       drop;
	} fifo_res_t;

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [aef_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
	logic [aef_pkg::WIN_W-1:0]     cfg_wdata = '0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [1:0]                    func = '0;
	logic [aef_pkg::CODE_W-1:0]    action_code = '0;
	logic [aef_pkg::DELTA_W-1:0]   delta_ticks = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [aef_pkg::CODE_W-1:0]    taken_code;
	logic [aef_pkg::CODE_W-1:0]    next_code;
	logic                          pending;
	logic [aef_pkg::OCC_W-1:0]     occupancy;
	logic                          accepted;
	logic                          dropped_oldest;

	// mirror of the fifo contents and registers
	logic [aef_pkg::CODE_W-1:0] mirror_code [FIFO_DEPTH];
	logic [31:0]                mirror_stamp [FIFO_DEPTH];
	int                         mirror_head = 0;
	int                         mirror_cnt = 0;
	logic [31:0]                mirror_now = '0;
	logic [aef_pkg::WIN_W-1:0]  mirror_win = aef_pkg::WINDOW_RESET;
	logic [aef_pkg::CAP_W-1:0]  mirror_cap = aef_pkg::CAP_RESET;

	fifo_req_t op_q[$];
	fifo_res_t result_q[$];
	int        n_sent = 0;
	int        n_taken = 0;
	int        err_cnt = 0;
	bit        fired = 1'b0;
	bit        calm = 1'b0;
	int        gap_left = 0;
	int        stall_left = 0;

	aging_event_fifo dut (.*);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic bit is_stale(int s);
		logic [31:0] age;
		age = mirror_now - mirror_stamp[s];
		return age > {1'b0, mirror_win};
	endfunction

	// drop expired entries anywhere in the ring, survivors keep their order
	function automatic void purge_stale();
		int kept;
		int src;
		int dst;
		kept = 0;
		for (int i = 0; i < mirror_cnt; i++) begin
			src = (mirror_head + i) % FIFO_DEPTH;
			if (!is_stale(src)) begin
				dst = (mirror_head + kept) % FIFO_DEPTH;
				mirror_code[dst] = mirror_code[src];
				mirror_stamp[dst] = mirror_stamp[src];
				kept++;
			end
		end
		mirror_cnt = kept;
	endfunction

	function automatic fifo_res_t fifo_apply(fifo_req_t r);
		fifo_res_t res;
		int lim;
		int s;
		res = '0;
		case (r.op)
			aef_pkg::FUNC_PUSH: begin
				if (r.code != '0) begin
					lim = (mirror_cap == 0) ? 1 :
						(mirror_cap > FIFO_DEPTH) ? FIFO_DEPTH : int'(mirror_cap);
					if (mirror_cnt >= lim && mirror_cnt > 0) begin
						mirror_head = (mirror_head + 1) % FIFO_DEPTH;
						mirror_cnt--;
						res.drop = 1'b1;
					end
					s = (mirror_head + mirror_cnt) % FIFO_DEPTH;
					mirror_code[s] = r.code;
					mirror_stamp[s] = mirror_now;
					mirror_cnt++;
					res.acc = 1'b1;
				end
			end
			aef_pkg::FUNC_CONSUME: begin
				purge_stale();
				if (mirror_cnt > 0) begin
					res.taken = mirror_code[mirror_head];
					mirror_head = (mirror_head + 1) % FIFO_DEPTH;
					mirror_cnt--;
				end
			end
			aef_pkg::FUNC_TICK: begin
				mirror_now = mirror_now + 32'(r.delta);
				purge_stale();
			end
			default: begin
				mirror_cnt = 0;
				mirror_head = 0;
			end
		endcase
		// a push leaves stale entries in place, so skip them here
		for (int i = 0; i < mirror_cnt; i++) begin
			s = (mirror_head + i) % FIFO_DEPTH;
			if (!is_stale(s)) begin
				res.next = mirror_code[s];
				res.pend = 1'b1;
				break;
			end
		end
		res.occ = aef_pkg::OCC_W'(mirror_cnt);
		return res;
	endfunction

	function automatic int pick_gap();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic fifo_req_t rand_op();
		fifo_req_t r;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		r.code = aef_pkg::CODE_W'($urandom);
		r.delta = aef_pkg::DELTA_W'($urandom);
		if (pick < 48) begin
			r.op = aef_pkg::FUNC_PUSH;
			if ($urandom_range(0, 19) == 0)
				r.code = '0;
		end else if (pick < 73) begin
			r.op = aef_pkg::FUNC_CONSUME;
		end else if (pick < 95) begin
			r.op = aef_pkg::FUNC_TICK;
			pick = $urandom_range(0, 9);
			if (pick < 6)
				r.delta = aef_pkg::DELTA_W'($urandom_range(0, 64));
			else if (pick < 9)
				r.delta = aef_pkg::DELTA_W'($urandom_range(0, 1000));
		end else begin
			r.op = aef_pkg::FUNC_CLEAR;
		end
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			err_cnt++;
		end
	endfunction

	task automatic queue_op(input aef_pkg::func_t op, input logic [aef_pkg::CODE_W-1:0] code,
			input logic [aef_pkg::DELTA_W-1:0] delta);
		fifo_req_t r;
		r.op = op;
		r.code = code;
		r.delta = delta;
		op_q.push_back(r);
		n_sent++;
	endtask

	task automatic wait_idle();
		while (n_taken != n_sent || result_q.size() != 0)
			@(negedge clk);
		repeat (25) @(negedge clk);
	endtask

	task automatic write_reg(input logic [aef_pkg::CFG_IDX_W-1:0] idx,
			input logic [aef_pkg::WIN_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == aef_pkg::CFG_WINDOW)
			mirror_win = val;
		else
			mirror_cap = val[aef_pkg::CAP_W-1:0];
	endtask

	// item driver
	always @(negedge clk) begin : drv
		fifo_req_t r;
		if (arst_n && (!in_valid || fired)) begin
			fired = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (op_q.size() != 0) begin
				r = op_q.pop_front();
				in_valid <= 1'b1;
				func <= r.op;
				action_code <= r.code;
				delta_ticks <= r.delta;
				gap_left = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result backpressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			stall_left = pick_gap();
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : mon
		fifo_req_t r;
		fifo_res_t e;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				r.op = aef_pkg::func_t'(func);
				r.code = action_code;
				r.delta = delta_ticks;
				result_q.push_back(fifo_apply(r));
				n_taken++;
				fired = 1'b1;
			end
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					$error("result with no item outstanding");
					err_cnt++;
				end else begin
					e = result_q.pop_front();
					check_field("taken_code", e.taken, taken_code);
					check_field("next_code", e.next, next_code);
					check_field("pending", e.pend, pending);
					check_field("occupancy", e.occ, occupancy);
					check_field("accepted", e.acc, accepted);
					check_field("dropped_oldest", e.drop, dropped_oldest);
				end
			end
		end
	end

	initial begin
		fifo_req_t r;
		logic [aef_pkg::WIN_W-1:0] win_v;
		logic [aef_pkg::CAP_W-1:0] cap_v;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty consume, zero code, field extremes, expiry by tick
		queue_op(aef_pkg::FUNC_CONSUME, 8'h00, 16'h0000);
		queue_op(aef_pkg::FUNC_PUSH, 8'h00, 16'hffff);
		queue_op(aef_pkg::FUNC_PUSH, 8'hff, 16'h0000);
		queue_op(aef_pkg::FUNC_PUSH, 8'h01, 16'hffff);
		queue_op(aef_pkg::FUNC_PUSH, 8'h80, 16'h0000);
		queue_op(aef_pkg::FUNC_TICK, 8'hff, 16'h0000);
		queue_op(aef_pkg::FUNC_CONSUME, 8'hff, 16'hffff);
		queue_op(aef_pkg::FUNC_TICK, 8'h00, 16'd150);
		queue_op(aef_pkg::FUNC_PUSH, 8'haa, 16'h0000);
		queue_op(aef_pkg::FUNC_TICK, 8'h00, 16'd60);
		queue_op(aef_pkg::FUNC_PUSH, 8'h55, 16'h0000);
		queue_op(aef_pkg::FUNC_TICK, 8'h00, 16'hffff);
		queue_op(aef_pkg::FUNC_PUSH, 8'h7e, 16'h0000);
		queue_op(aef_pkg::FUNC_CLEAR, 8'hff, 16'hffff);
		queue_op(aef_pkg::FUNC_PUSH, 8'h11, 16'h0000);
		queue_op(aef_pkg::FUNC_PUSH, 8'h22, 16'h0000);
		queue_op(aef_pkg::FUNC_PUSH, 8'h33, 16'h0000);
		queue_op(aef_pkg::FUNC_TICK, 8'h00, 16'd10);
		wait_idle();

		// zero window leaves stored entries stale; push must skip them
		write_reg(aef_pkg::CFG_WINDOW, '0);
		queue_op(aef_pkg::FUNC_PUSH, 8'h44, 16'h0000);
		wait_idle();
		// capacity below occupancy evicts only one per push
		write_reg(aef_pkg::CFG_CAPACITY, aef_pkg::WIN_W'(2));
		queue_op(aef_pkg::FUNC_PUSH, 8'h66, 16'h0000);
		queue_op(aef_pkg::FUNC_CONSUME, 8'h00, 16'h0000);
		wait_idle();
		write_reg(aef_pkg::CFG_CAPACITY, '0);
		queue_op(aef_pkg::FUNC_PUSH, 8'h01, 16'h0000);
		queue_op(aef_pkg::FUNC_PUSH, 8'h02, 16'h0000);
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin win_v = aef_pkg::WINDOW_RESET; cap_v = aef_pkg::CAP_RESET; end
				1: begin win_v = '0; cap_v = 5'd1; end
				2: begin win_v = '1; cap_v = 5'd31; end
				3: begin win_v = aef_pkg::WIN_W'($urandom_range(1, 500)); cap_v = '0; end
				4: begin
					win_v = aef_pkg::WIN_W'($urandom);
					cap_v = aef_pkg::CAP_W'($urandom_range(0, 31));
				end
				5: begin
					win_v = aef_pkg::WIN_W'($urandom_range(50, 3000));
					cap_v = aef_pkg::CAP_W'($urandom_range(1, 16));
				end
				6: begin win_v = aef_pkg::WIN_W'(300); cap_v = 5'd4; end
				default: begin
					win_v = aef_pkg::WIN_W'($urandom_range(1, 1000));
					cap_v = aef_pkg::CAP_W'($urandom_range(2, 16));
				end
			endcase
			calm = (ph == 2 || ph == 5);
			write_reg(aef_pkg::CFG_WINDOW, win_v);
			write_reg(aef_pkg::CFG_CAPACITY, aef_pkg::WIN_W'(cap_v));
			repeat (190) begin
				r = rand_op();
				queue_op(r.op, r.code, r.delta);
			end
			wait_idle();
		end

		// older entries expire under a wide window while a newer one survives
		calm = 1'b1;
		write_reg(aef_pkg::CFG_WINDOW, aef_pkg::WIN_W'(1000));
		write_reg(aef_pkg::CFG_CAPACITY, aef_pkg::WIN_W'(16));
		queue_op(aef_pkg::FUNC_CLEAR, 8'h00, 16'h0000);
		queue_op(aef_pkg::FUNC_PUSH, 8'h5a, 16'h0000);
		queue_op(aef_pkg::FUNC_PUSH, 8'ha5, 16'h0000);
		queue_op(aef_pkg::FUNC_TICK, 8'h00, 16'd400);
		queue_op(aef_pkg::FUNC_PUSH, 8'hc3, 16'h0000);
		queue_op(aef_pkg::FUNC_TICK, 8'h00, 16'd700);
		queue_op(aef_pkg::FUNC_CONSUME, 8'h00, 16'h0000);
		queue_op(aef_pkg::FUNC_CONSUME, 8'h00, 16'h0000);
		wait_idle();

		if (err_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/aef_pkg.sv
hw/rtl/aef_dp.sv
hw/rtl/aef_ctrl.sv
hw/rtl/aging_event_fifo.sv
sim/aging_event_fifo_tb.sv
